@@ rtl/u8sd_pkg.sv @@
// Package for the UTF-8 stream decoder: field widths, code point constants
// and the result record shared by the core and the top level.
// Depends on nothing.
`default_nettype none

package u8sd_pkg;

	localparam int BYTE_W = 8;
	localparam int CP_W   = 21;
	localparam int PEND_W = 3;

	localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;
	localparam logic [CP_W-1:0] MAX_CP  = 21'h10FFFF;

	localparam logic [BYTE_W-1:0] MIN_LEAD2 = 8'hC2;
	localparam logic [BYTE_W-1:0] MAX_LEAD4 = 8'hF4;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            replaced;
		logic            last;
		logic            string_valid;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/u8sd_byte_if.sv @@
// Channel carrying one UTF-8 byte per request with its end-of-string mark.
// Depends on u8sd_pkg.
`default_nettype none

interface u8sd_byte_if;
	logic                          valid;
	logic                          ready;
	logic [u8sd_pkg::BYTE_W-1:0]   byte_in;
	logic                          end_of_string;

	modport source (output valid, output byte_in, output end_of_string, input ready);
	modport sink (input valid, input byte_in, input end_of_string, output ready);
endinterface

`default_nettype wire

@@ rtl/u8sd_cp_if.sv @@
// Channel carrying one decoded code point per request with its status flags.
// Depends on u8sd_pkg.
`default_nettype none

interface u8sd_cp_if;
	logic                        valid;
	logic                        ready;
	logic [u8sd_pkg::CP_W-1:0]   code_point;
	logic                        replaced;
	logic                        last;
	logic                        string_valid;

	modport source (output valid, output code_point, output replaced, output last,
		output string_valid, input ready);
	modport sink (input valid, input code_point, input replaced, input last,
		input string_valid, output ready);
endinterface

`default_nettype wire

@@ rtl/u8sd_core.sv @@
// Decoder state (pending count, accumulator, character and string flags) and
// the single-pass decode of one byte into at most one result.
// Depends on u8sd_pkg.
`default_nettype none

module u8sd_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic [u8sd_pkg::BYTE_W-1:0]   byte_in,
	input  wire logic                          end_of_string,
	output      logic                          res_valid,
	output      u8sd_pkg::result_t             res
);
	import u8sd_pkg::*;

	logic [PEND_W-1:0] pend_q, pend_d;
	logic [CP_W-1:0]   acc_q, acc_d;
	logic              char_ok_q, char_ok_d;
	logic              stream_ok_q, stream_ok_d;
	logic              emit;
	logic [CP_W-1:0]   cp;
	logic              repl;
	logic              is_cont;

	assign is_cont = (byte_in[7:6] == 2'b10);

	always_comb begin
		pend_d      = pend_q;
		acc_d       = acc_q;
		char_ok_d   = char_ok_q;
		stream_ok_d = stream_ok_q;
		emit        = 1'b0;
		cp          = REPL_CP;
		repl        = 1'b1;

		if (pend_q != '0) begin
			if (is_cont) begin
				acc_d = {acc_q[CP_W-7:0], byte_in[5:0]};
			end else begin
				char_ok_d   = 1'b0;
				stream_ok_d = 1'b0;
			end
			pend_d = pend_q - 1'b1;
			if (pend_d == '0) begin
				emit = 1'b1;
				if (char_ok_d && (acc_d <= MAX_CP)) begin
					cp   = acc_d;
					repl = 1'b0;
				end
			end
		end else begin
			priority if (byte_in[7] == 1'b0) begin
				emit = 1'b1;
				cp   = {{(CP_W-BYTE_W){1'b0}}, byte_in};
				repl = 1'b0;
			end else if (byte_in[7:5] == 3'b110) begin
				char_ok_d   = (byte_in >= MIN_LEAD2);
				stream_ok_d = stream_ok_q && char_ok_d;
				acc_d       = {{(CP_W-5){1'b0}}, byte_in[4:0]};
				pend_d      = 3'd1;
			end else if (byte_in[7:4] == 4'b1110) begin
				char_ok_d = 1'b1;
				acc_d     = {{(CP_W-4){1'b0}}, byte_in[3:0]};
				pend_d    = 3'd2;
			end else if (byte_in[7:3] == 5'b11110) begin
				char_ok_d   = (byte_in <= MAX_LEAD4);
				stream_ok_d = stream_ok_q && char_ok_d;
				acc_d       = {{(CP_W-3){1'b0}}, byte_in[2:0]};
				pend_d      = 3'd3;
			end else if (byte_in[7:2] == 6'b111110) begin
				char_ok_d   = 1'b0;
				stream_ok_d = 1'b0;
				acc_d       = {{(CP_W-2){1'b0}}, byte_in[1:0]};
				pend_d      = 3'd4;
			end else if (byte_in[7:1] == 7'b1111110) begin
				char_ok_d   = 1'b0;
				stream_ok_d = 1'b0;
				acc_d       = {{(CP_W-1){1'b0}}, byte_in[0]};
				pend_d      = 3'd5;
			end else begin
				stream_ok_d = 1'b0;
				emit        = 1'b1;
			end
		end

		res.last         = end_of_string;
		res.string_valid = 1'b0;
		if (end_of_string) begin
			if (pend_d != '0) begin
				stream_ok_d = 1'b0;
				emit        = 1'b1;
				cp          = REPL_CP;
				repl        = 1'b1;
			end
			res.string_valid = stream_ok_d;
			pend_d      = '0;
			acc_d       = '0;
			char_ok_d   = 1'b0;
			stream_ok_d = 1'b1;
		end

		res.code_point = cp;
		res.replaced   = repl;
		res_valid      = emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			acc_q       <= '0;
			char_ok_q   <= 1'b0;
			stream_ok_q <= 1'b1;
		end else if (step) begin
			pend_q      <= pend_d;
			acc_q       <= acc_d;
			char_ok_q   <= char_ok_d;
			stream_ok_q <= stream_ok_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/utf8_stream_decoder_unit.sv @@
// UTF-8 stream decoder top level: input register, decode core, result register.
// A result is registered when the core steps the byte held in the input register.
// Throughput: one byte per cycle while the output is not stalled.
// A byte is taken while a result waits, unless a stall holds the input register.
// Reset clears the pipeline valid flags and the decode state; the string flag
// starts valid. Depends on u8sd_pkg, u8sd_byte_if, u8sd_cp_if and u8sd_core.
`default_nettype none

module utf8_stream_decoder_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	u8sd_byte_if.sink   byte_stream,
	u8sd_cp_if.source   code_points
);
	import u8sd_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              eos_s1;
	logic              valid_s2;
	result_t           res_s2;
	logic              adv;
	logic              core_valid;
	result_t           core_res;

	assign adv               = valid_s1 && (!valid_s2 || code_points.ready);
	assign byte_stream.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			valid_s1 <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.valid && byte_stream.ready) begin
			byte_s1 <= byte_stream.byte_in;
			eos_s1  <= byte_stream.end_of_string;
		end
	end

	u8sd_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (adv),
		.byte_in       (byte_s1),
		.end_of_string (eos_s1),
		.res_valid     (core_valid),
		.res           (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= core_valid;
		end else if (code_points.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && core_valid) begin
			res_s2 <= core_res;
		end
	end

	assign code_points.valid        = valid_s2;
	assign code_points.code_point   = res_s2.code_point;
	assign code_points.replaced     = res_s2.replaced;
	assign code_points.last         = res_s2.last;
	assign code_points.string_valid = res_s2.string_valid;

endmodule

`default_nettype wire

@@ tb/tb_utf8_stream_decoder_unit.sv @@
// Self-checking testbench for utf8_stream_decoder_unit: a short table of
// directed bytes, then random strings of UTF-8 characters and broken sequences.
// Depends on u8sd_pkg, u8sd_byte_if, u8sd_cp_if and the decoder RTL.

module tb_utf8_stream_decoder_unit;
	import u8sd_pkg::*;

	localparam int N_DIRECTED    = 27;
	localparam int RANDOM_ITEMS  = 1250;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int MAX_REPORTS   = 50;
	localparam int DRAIN_CYCLES  = 10;

	typedef enum logic {PREDICTED, TYPED_IN} row_kind_t;

	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              eos;
		row_kind_t         kind;
		result_t           lit;
	} stim_row_t;

	localparam result_t NO_RESULT = '0;

	logic clk = 1'b0;
	logic arst_n;

	u8sd_byte_if byte_ch();
	u8sd_cp_if   cp_ch();

	utf8_stream_decoder_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_stream(byte_ch),
		.code_points(cp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decoder state as seen by the predictor.
	logic [PEND_W-1:0] dec_pending = '0;
	logic [30:0]       dec_acc = '0;
	logic              dec_char_ok = 1'b0;
	logic              dec_string_ok = 1'b1;

	result_t           awaited_code_points[$];
	logic [BYTE_W-1:0] string_bytes[$];
	int unsigned       mismatches = 0;
	int unsigned       sent_count = 0;
	int unsigned       burst_left = 0;
	int unsigned       cycle_count = 0;

	stim_row_t directed_rows [N_DIRECTED] = '{
		'{8'h00, 1'b0, TYPED_IN,  {21'h000000, 1'b0, 1'b0, 1'b0}},
		'{8'h7F, 1'b1, TYPED_IN,  {21'h00007F, 1'b0, 1'b1, 1'b1}},
		'{8'hF4, 1'b0, PREDICTED, NO_RESULT},
		'{8'h90, 1'b0, PREDICTED, NO_RESULT},
		'{8'h80, 1'b0, PREDICTED, NO_RESULT},
		'{8'h80, 1'b1, TYPED_IN,  {REPL_CP, 1'b1, 1'b1, 1'b1}},
		'{8'hEF, 1'b0, PREDICTED, NO_RESULT},
		'{8'hBF, 1'b0, PREDICTED, NO_RESULT},
		'{8'hBD, 1'b0, PREDICTED, NO_RESULT},
		'{8'hED, 1'b0, PREDICTED, NO_RESULT},
		'{8'hA0, 1'b0, PREDICTED, NO_RESULT},
		'{8'h80, 1'b0, PREDICTED, NO_RESULT},
		'{8'hC1, 1'b0, PREDICTED, NO_RESULT},
		'{8'hBF, 1'b0, TYPED_IN,  {REPL_CP, 1'b1, 1'b0, 1'b0}},
		'{8'h80, 1'b0, TYPED_IN,  {REPL_CP, 1'b1, 1'b0, 1'b0}},
		'{8'hFE, 1'b0, TYPED_IN,  {REPL_CP, 1'b1, 1'b0, 1'b0}},
		'{8'hC2, 1'b0, PREDICTED, NO_RESULT},
		'{8'h41, 1'b0, TYPED_IN,  {REPL_CP, 1'b1, 1'b0, 1'b0}},
		'{8'hFC, 1'b0, PREDICTED, NO_RESULT},
		'{8'h80, 1'b0, PREDICTED, NO_RESULT},
		'{8'h80, 1'b0, PREDICTED, NO_RESULT},
		'{8'h80, 1'b0, PREDICTED, NO_RESULT},
		'{8'h80, 1'b0, PREDICTED, NO_RESULT},
		'{8'h80, 1'b1, TYPED_IN,  {REPL_CP, 1'b1, 1'b1, 1'b0}},
		'{8'hE0, 1'b0, PREDICTED, NO_RESULT},
		'{8'h80, 1'b1, TYPED_IN,  {REPL_CP, 1'b1, 1'b1, 1'b0}},
		'{8'hFF, 1'b1, TYPED_IN,  {REPL_CP, 1'b1, 1'b1, 1'b0}}
	};

	task automatic decode_utf8_byte(input logic [BYTE_W-1:0] b, input logic eos,
		output logic has_res, output result_t res);
		has_res = 1'b0;
		res = '0;
		if (dec_pending != 0) begin
			if (b[7:6] == 2'b10) begin
				dec_acc = {dec_acc[24:0], b[5:0]};
			end else begin
				dec_char_ok = 1'b0;
				dec_string_ok = 1'b0;
			end
			dec_pending = dec_pending - 1'b1;
			if (dec_pending == 0) begin
				has_res = 1'b1;
				if (dec_char_ok && dec_acc <= {10'd0, MAX_CP}) begin
					res.code_point = dec_acc[CP_W-1:0];
				end else begin
					res.code_point = REPL_CP;
					res.replaced = 1'b1;
				end
			end
		end else if (b[7] == 1'b0) begin
			has_res = 1'b1;
			res.code_point = CP_W'(b);
		end else if (b[7:5] == 3'b110) begin
			dec_char_ok = (b >= MIN_LEAD2);
			if (!dec_char_ok) dec_string_ok = 1'b0;
			dec_acc = 31'(b[4:0]);
			dec_pending = 3'd1;
		end else if (b[7:4] == 4'b1110) begin
			dec_char_ok = 1'b1;
			dec_acc = 31'(b[3:0]);
			dec_pending = 3'd2;
		end else if (b[7:3] == 5'b11110) begin
			dec_char_ok = (b <= MAX_LEAD4);
			if (!dec_char_ok) dec_string_ok = 1'b0;
			dec_acc = 31'(b[2:0]);
			dec_pending = 3'd3;
		end else if (b[7:2] == 6'b111110) begin
			dec_char_ok = 1'b0;
			dec_string_ok = 1'b0;
			dec_acc = 31'(b[1:0]);
			dec_pending = 3'd4;
		end else if (b[7:1] == 7'b1111110) begin
			dec_char_ok = 1'b0;
			dec_string_ok = 1'b0;
			dec_acc = 31'(b[0]);
			dec_pending = 3'd5;
		end else begin
			dec_string_ok = 1'b0;
			has_res = 1'b1;
			res.code_point = REPL_CP;
			res.replaced = 1'b1;
		end
		if (eos) begin
			if (dec_pending != 0) begin
				dec_string_ok = 1'b0;
				has_res = 1'b1;
				res.code_point = REPL_CP;
				res.replaced = 1'b1;
			end
			res.last = 1'b1;
			res.string_valid = dec_string_ok;
			dec_pending = '0;
			dec_acc = '0;
			dec_char_ok = 1'b0;
			dec_string_ok = 1'b1;
		end
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	// Sends one byte request in bursts with random gaps, then records what it should yield.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos,
		input row_kind_t kind, input result_t lit);
		int unsigned gap;
		logic        has_res;
		result_t     res;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				byte_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		byte_ch.valid <= 1'b1;
		byte_ch.byte_in <= b;
		byte_ch.end_of_string <= eos;
		@(posedge clk);
		while (byte_ch.ready !== 1'b1) @(posedge clk);
		burst_left--;
		sent_count++;
		decode_utf8_byte(b, eos, has_res, res);
		if (kind == TYPED_IN)
			awaited_code_points.push_back(lit);
		else if (has_res)
			awaited_code_points.push_back(res);
	endtask

	task automatic wait_for_all_results();
		byte_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (awaited_code_points.size() != 0);
	endtask

	function automatic logic [CP_W-1:0] random_code_point(input int unsigned len);
		case (len)
			1: return CP_W'($urandom_range(0, 'h7F));
			2: return CP_W'($urandom_range(0, 'h7FF));
			3: return CP_W'($urandom_range(0, 'hFFFF));
			default: begin
				if ($urandom_range(0, 7) == 0)
					return CP_W'($urandom_range(0, 'h1FFFFF));
				return CP_W'($urandom_range(0, 'h10FFFF));
			end
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] continuation_byte(input logic [5:0] payload);
		return {2'b10, payload};
	endfunction

	task automatic append_utf8(input logic [CP_W-1:0] cp, input int unsigned len);
		case (len)
			1: string_bytes.push_back({1'b0, cp[6:0]});
			2: begin
				string_bytes.push_back({3'b110, cp[10:6]});
				string_bytes.push_back(continuation_byte(cp[5:0]));
			end
			3: begin
				string_bytes.push_back({4'b1110, cp[15:12]});
				string_bytes.push_back(continuation_byte(cp[11:6]));
				string_bytes.push_back(continuation_byte(cp[5:0]));
			end
			default: begin
				string_bytes.push_back({5'b11110, cp[20:18]});
				string_bytes.push_back(continuation_byte(cp[17:12]));
				string_bytes.push_back(continuation_byte(cp[11:6]));
				string_bytes.push_back(continuation_byte(cp[5:0]));
			end
		endcase
	endtask

	// Mostly well-formed characters, some with overlong or out-of-range content.
	// The rest are long leads, cut-off sequences and arbitrary bytes.
	task automatic add_random_char();
		int unsigned       pick;
		int unsigned       len;
		logic [BYTE_W-1:0] lead;
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			len = $urandom_range(1, 4);
			append_utf8(random_code_point(len), len);
		end else if (pick < 75) begin
			lead = BYTE_W'($urandom_range('hF8, 'hFD));
			string_bytes.push_back(lead);
			repeat ((lead >= 8'hFC) ? 5 : 4)
				string_bytes.push_back(continuation_byte(6'($urandom_range(0, 63))));
		end else if (pick < 85) begin
			len = $urandom_range(2, 4);
			append_utf8(random_code_point(len), len);
			repeat ($urandom_range(1, len - 1)) void'(string_bytes.pop_back());
		end else begin
			string_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
		end
	endtask

	logic [15:0] stall_pattern = '1;
	int unsigned pattern_age = 0;

	always @(posedge clk) begin
		if (pattern_age == 0) begin
			pattern_age <= $urandom_range(16, 96);
			if ($urandom_range(0, 2) == 0)
				stall_pattern <= '1;
			else if ($urandom_range(0, 3) == 0)
				stall_pattern <= 16'h8000;
			else
				stall_pattern <= 16'($urandom);
		end else begin
			pattern_age <= pattern_age - 1;
			stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
		end
		cp_ch.ready <= stall_pattern[0];
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n === 1'b1 && cp_ch.valid === 1'b1 && cp_ch.ready === 1'b1) begin
			if (awaited_code_points.size() == 0) begin
				report_mismatch("unexpected code point", 32'(cp_ch.code_point), 0);
			end else begin
				want = awaited_code_points.pop_front();
				if (cp_ch.code_point !== want.code_point)
					report_mismatch("code_point", 32'(cp_ch.code_point),
						32'(want.code_point));
				if (cp_ch.replaced !== want.replaced)
					report_mismatch("replaced", 32'(cp_ch.replaced), 32'(want.replaced));
				if (cp_ch.last !== want.last)
					report_mismatch("last", 32'(cp_ch.last), 32'(want.last));
				if (cp_ch.string_valid !== want.string_valid)
					report_mismatch("string_valid", 32'(cp_ch.string_valid),
						32'(want.string_valid));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int unsigned n_chars;
		arst_n <= 1'b0;
		byte_ch.valid <= 1'b0;
		byte_ch.byte_in <= '0;
		byte_ch.end_of_string <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].data, directed_rows[i].eos,
				directed_rows[i].kind, directed_rows[i].lit);
		wait_for_all_results();

		while (sent_count < N_DIRECTED + RANDOM_ITEMS) begin
			string_bytes.delete();
			n_chars = $urandom_range(1, 6);
			repeat (n_chars) add_random_char();
			foreach (string_bytes[i])
				send_byte(string_bytes[i], i == string_bytes.size() - 1, PREDICTED, NO_RESULT);
			if ($urandom_range(0, 29) == 0) wait_for_all_results();
		end

		wait_for_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ files.f @@
rtl/u8sd_pkg.sv
rtl/u8sd_byte_if.sv
rtl/u8sd_cp_if.sv
rtl/u8sd_core.sv
rtl/utf8_stream_decoder_unit.sv
tb/tb_utf8_stream_decoder_unit.sv
